// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by sliding_window_min_max
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held low
`define SWMM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SWMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg
// types, constants and compare helpers for the sliding window min/max block
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH   = 32;
    localparam int CFG_WIDTH      = 11;
    localparam int DEF_MAX_WINDOW = 1024;

    // input request payload
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           end_of_sequence;
    } swmm_in_t;

    // result payload
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] window_min;
        logic signed [SAMPLE_WIDTH-1:0] window_max;
        logic                           last_of_sequence;
    } swmm_out_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;     // a sample is accepted this cycle
        logic seed_all;  // first sample of a sequence: every cell loads it
    } cell_ctrl_t;

    function automatic logic signed [SAMPLE_WIDTH-1:0] smin(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] smax(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/swmm_cell.sv -----
// ----------------------------------------------------------------------------
// swmm_cell
// one stage of the min/max chain: holds the min and max over a suffix of
// the window that grows by one sample per stage towards the output end
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_cell import swmm_pkg::*; #(
    parameter  int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter  int INDEX      = 1,
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  wire logic                           aclk,
    input  wire cell_ctrl_t                     ctrl,
    input  wire logic [IDX_W-1:0]               w_last,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] nb_min,
    input  wire logic signed [SAMPLE_WIDTH-1:0] nb_max,
    output logic signed [SAMPLE_WIDTH-1:0]      o_min,
    output logic signed [SAMPLE_WIDTH-1:0]      o_max
);

    logic                           seed;
    logic signed [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;

    // entry stage of the window (or beyond it) starts from the new sample
    assign seed = ctrl.seed_all || (IDX_W'(INDEX) >= w_last);

    // fold the new sample into the neighbour's running min/max
    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.shift) begin
            min_next = seed ? sample : smin(sample, nb_min);
            max_next = seed ? sample : smax(sample, nb_max);
        end
    end

    always_ff @(posedge aclk) begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign o_min = min_reg;
    assign o_max = max_reg;

endmodule

`default_nettype wire

// ----- rtl/sliding_window_min_max.sv -----
// The block accepts one sample per clock cycle; once the window is full or a
// sequence ends, the result is registered. Input is held off only while a
// result sits in the output register and the sink does not take it. The rate
// is set by a row of MAX_WINDOW-1 cells, each holding the min and max over a
// window suffix and updating from its neighbour in the accept cycle, so no
// search over stored samples and no clearing pass after reset are needed.
// ----------------------------------------------------------------------------
// sliding_window_min_max
// minimum and maximum over the last window_size samples of a stream, with
// a short result at the end of a sequence that never filled the window
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sliding_window_min_max import swmm_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire swmm_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output swmm_out_t                 m_data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [IDX_W-1:0] w_last_reg, w_last_next;
    logic [CNT_W-1:0] w_eff_reg, w_eff_next;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_inc;
    logic             started_reg, started_next;
    logic             m_valid_reg, m_valid_next;
    swmm_out_t        m_data_reg, m_data_next;

    logic [31:0]      cfg_weff;
    logic             acc;
    logic             has_result;
    logic             seed0;
    cell_ctrl_t       ctrl;

    logic signed [SAMPLE_WIDTH-1:0] nb_min [MAX_WINDOW:1];
    logic signed [SAMPLE_WIDTH-1:0] nb_max [MAX_WINDOW:1];

    // handshake: output register frees up as it drains
    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;

    // effective window from the written value: zero acts as one, saturate high
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_weff = 32'd1;
        end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
            cfg_weff = 32'(MAX_WINDOW);
        end else begin
            cfg_weff = 32'(cfg_wdata);
        end
    end

    // sample count of the sequence, saturating at the deepest window
    assign fill_inc   = (fill_reg < CNT_W'(MAX_WINDOW)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign has_result = (fill_inc >= w_eff_reg) || s_data.end_of_sequence;

    // control broadcast to the chain
    assign ctrl.shift    = acc;
    assign ctrl.seed_all = !started_reg;

    // chain tail sees the new sample itself
    assign nb_min[MAX_WINDOW] = s_data.sample;
    assign nb_max[MAX_WINDOW] = s_data.sample;

    // row of cells, data moving towards index one
    for (genvar k = 1; k < MAX_WINDOW; k++) begin : g_cell
        swmm_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .INDEX      (k)
        ) u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .w_last (w_last_reg),
            .sample (s_data.sample),
            .nb_min (nb_min[k+1]),
            .nb_max (nb_max[k+1]),
            .o_min  (nb_min[k]),
            .o_max  (nb_max[k])
        );
    end

    // front stage: window min/max including the new sample
    assign seed0 = !started_reg || (w_last_reg == '0);

    always_comb begin
        m_data_next.window_min       = seed0 ? s_data.sample
                                             : smin(s_data.sample, nb_min[1]);
        m_data_next.window_max       = seed0 ? s_data.sample
                                             : smax(s_data.sample, nb_max[1]);
        m_data_next.last_of_sequence = s_data.end_of_sequence;
    end

    // sequence and window control
    always_comb begin
        w_last_next  = w_last_reg;
        w_eff_next   = w_eff_reg;
        fill_next    = fill_reg;
        started_next = started_reg;
        if (cfg_we) begin
            w_last_next  = IDX_W'(cfg_weff - 32'd1);
            w_eff_next   = CNT_W'(cfg_weff);
            fill_next    = '0;
            started_next = 1'b0;
        end else if (acc) begin
            if (s_data.end_of_sequence) begin
                fill_next    = '0;
                started_next = 1'b0;
            end else begin
                fill_next    = fill_inc;
                started_next = 1'b1;
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (acc && has_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg  <= '0;
            w_eff_reg   <= CNT_W'(1);
            fill_reg    <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            w_last_reg  <= w_last_next;
            w_eff_reg   <= w_eff_next;
            fill_reg    <= fill_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && has_result) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SWMM_ASSERT(a_eos_gives_result, aclk, aresetn, (acc && s_data.end_of_sequence) |=> (m_valid_reg && m_data_reg.last_of_sequence), "end of sequence request gave no final result")
    `SWMM_ASSERT(a_eos_clears, aclk, aresetn, (acc && s_data.end_of_sequence) |=> (fill_reg == '0 && !started_reg), "sequence state not cleared after end of sequence")
    `SWMM_ASSERT(a_stall_blocks_input, aclk, aresetn, (m_valid_reg && !m_ready) |-> !s_ready, "input taken while result is stalled")
    `SWMM_ASSERT(a_min_le_max, aclk, aresetn, m_valid_reg |-> (m_data_reg.window_min <= m_data_reg.window_max), "window minimum above maximum")

endmodule

`default_nettype wire
